### hdl/qau_pkg.sv
// Shared selector codes and product sign table for the quaternion arithmetic unit.
package qau_pkg;

	typedef logic [1:0] func_t;

	localparam func_t FUNC_MUL  = 2'd0;
	localparam func_t FUNC_ROT  = 2'd1;
	localparam func_t FUNC_NORM = 2'd2;

	// Negated terms of the Hamilton product, indexed [row][term]. Term k of row r
	// multiplies p[k] by q[r ^ k].
	localparam logic [3:0][3:0] HAM_NEG = {4'b0100, 4'b0010, 4'b1000, 4'b1110};

endpackage

### hdl/quaternion_arith_unit.sv
// Quaternion multiply, rotate and normalize unit on a fully pipelined datapath.

// The unit takes one word per cycle while in_stall is low and returns one word per word,
// in order. The first four stages form the product sums and the rotation; the pipeline
// depth is set by the square root, which resolves one root bit per stage over
// COMP_WIDTH + 1 stages, and by the four dividers of normalize, which resolve one
// quotient bit per stage over FRAC_BITS + 1 stages. Every selector takes the same path
// length. When out_stall holds a waiting result, the whole pipeline holds with it and
// in_stall is raised.
module quaternion_arith_unit #(
	parameter int COMP_WIDTH = 16,
	parameter int FRAC_BITS  = 14
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  qau_pkg::func_t               func,
	input  logic signed [COMP_WIDTH-1:0] a_w,
	input  logic signed [COMP_WIDTH-1:0] a_x,
	input  logic signed [COMP_WIDTH-1:0] a_y,
	input  logic signed [COMP_WIDTH-1:0] a_z,
	input  logic signed [COMP_WIDTH-1:0] b_w,
	input  logic signed [COMP_WIDTH-1:0] b_x,
	input  logic signed [COMP_WIDTH-1:0] b_y,
	input  logic signed [COMP_WIDTH-1:0] b_z,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [COMP_WIDTH-1:0] r_w,
	output logic signed [COMP_WIDTH-1:0] r_x,
	output logic signed [COMP_WIDTH-1:0] r_y,
	output logic signed [COMP_WIDTH-1:0] r_z,
	output logic                         saturated,
	output logic                         zero_magnitude
);
	import qau_pkg::*;

	localparam int W    = COMP_WIDTH;
	localparam int F    = FRAC_BITS;
	localparam int PW   = 2 * W;
	localparam int SUMW = 2 * W + 2;
	localparam int HW   = SUMW - F;
	localparam int RPW  = HW + W;
	localparam int RSW  = RPW + 2;
	localparam int RHW  = RSW - F;
	localparam int SATW = ((HW > RHW) ? ((HW > W) ? HW : W) : ((RHW > W) ? RHW : W)) + 1;
	localparam int SW   = SUMW;
	localparam int NR   = W + 1;
	localparam int REMW = NR + 2;
	localparam int QB   = F + 1;
	localparam int NW   = W + F + 1;
	localparam int CW   = ((QB > W) ? QB : W) + 1;

	typedef struct packed {
		func_t                func;
		logic                 zero;
		logic [3:0]           aneg;
		logic [3:0][W-1:0]    amag;
		logic [3:0][W-1:0]    r01;
		logic                 sat01;
	} side_t;

	function automatic logic [W:0] sat_w(input logic signed [SATW-1:0] v);
		logic signed [SATW-1:0] maxv;
		logic signed [SATW-1:0] minv;
		maxv = {{(SATW - W + 1){1'b0}}, {(W - 1){1'b1}}};
		minv = {{(SATW - W + 1){1'b1}}, {(W - 1){1'b0}}};
		if (v > maxv) begin
			return {1'b1, maxv[W-1:0]};
		end else if (v < minv) begin
			return {1'b1, minv[W-1:0]};
		end
		return {1'b0, v[W-1:0]};
	endfunction

	logic en;
	logic out_valid_q;
	logic signed [W-1:0] r_q [4];
	logic sat_q;
	logic zero_q;

	assign en       = !out_valid_q || !out_stall;
	assign in_stall = !en;

	// Stage 1: sixteen products.
	logic signed [W-1:0] av_in [4];
	logic signed [W-1:0] bv_in [4];
	logic signed [W-1:0] qv_in [4];

	assign av_in[0] = a_w;
	assign av_in[1] = a_x;
	assign av_in[2] = a_y;
	assign av_in[3] = a_z;
	assign bv_in[0] = b_w;
	assign bv_in[1] = b_x;
	assign bv_in[2] = b_y;
	assign bv_in[3] = b_z;

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			if (func == FUNC_NORM) begin
				qv_in[j] = av_in[j];
			end else if (func == FUNC_ROT && j == 0) begin
				qv_in[j] = '0;
			end else begin
				qv_in[j] = bv_in[j];
			end
		end
	end

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	func_t func_s1, func_s2, func_s3;
	logic signed [W-1:0] av_s1 [4];
	logic signed [W-1:0] av_s2 [4];
	logic signed [W-1:0] av_s3 [4];
	logic signed [PW-1:0] prod_s1 [4][4];

	always_ff @(posedge clk) begin
		if (en) begin
			func_s1 <= func;
			for (int r = 0; r < 4; r++) begin
				av_s1[r] <= av_in[r];
				for (int k = 0; k < 4; k++) begin
					prod_s1[r][k] <= av_in[k] * qv_in[r ^ k];
				end
			end
		end
	end

	// Stage 2: product sums, rounding, sum of squares.
	logic signed [SUMW-1:0] hsum [4];
	logic signed [SUMW-1:0] hrnd [4];
	logic signed [HW-1:0] h_s2 [4];
	logic signed [HW-1:0] h_s3 [4];
	logic [SW-1:0] ssq_s2, ssq_s3, ssq_s4;

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			hsum[r] = '0;
			for (int k = 0; k < 4; k++) begin
				if (HAM_NEG[r][k] && func_s1 != FUNC_NORM) begin
					hsum[r] = hsum[r] - {{(SUMW - PW){prod_s1[r][k][PW-1]}}, prod_s1[r][k]};
				end else begin
					hsum[r] = hsum[r] + {{(SUMW - PW){prod_s1[r][k][PW-1]}}, prod_s1[r][k]};
				end
			end
			hrnd[r] = hsum[r] + (SUMW'(1) << (F - 1));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s2 <= func_s1;
			ssq_s2  <= hsum[0];
			for (int r = 0; r < 4; r++) begin
				av_s2[r] <= av_s1[r];
				h_s2[r]  <= hrnd[r][SUMW-1:F];
			end
		end
	end

	// Stage 3: products of the rotation's second pass.
	logic signed [RPW-1:0] pr_s3 [4][4];

	always_ff @(posedge clk) begin
		if (en) begin
			func_s3 <= func_s2;
			ssq_s3  <= ssq_s2;
			for (int r = 0; r < 4; r++) begin
				av_s3[r] <= av_s2[r];
				h_s3[r]  <= h_s2[r];
				for (int k = 0; k < 4; k++) begin
					pr_s3[r][k] <= h_s2[k] * av_s2[r ^ k];
				end
			end
		end
	end

	// Stage 4: rotation sums, saturation of multiply and rotate results.
	logic signed [RSW-1:0] rsum [4];
	logic signed [RSW-1:0] rrnd [4];
	logic [W:0] sat_mul [4];
	logic [W:0] sat_rot [4];
	side_t side_d4;
	side_t side_s4;

	always_comb begin
		side_d4.func  = func_s3;
		side_d4.zero  = (ssq_s3 == '0);
		side_d4.sat01 = 1'b0;
		for (int r = 0; r < 4; r++) begin
			rsum[r] = '0;
			for (int k = 0; k < 4; k++) begin
				if (HAM_NEG[r][k] ^ ((r ^ k) != 0)) begin
					rsum[r] = rsum[r] - {{(RSW - RPW){pr_s3[r][k][RPW-1]}}, pr_s3[r][k]};
				end else begin
					rsum[r] = rsum[r] + {{(RSW - RPW){pr_s3[r][k][RPW-1]}}, pr_s3[r][k]};
				end
			end
			rrnd[r] = rsum[r] + (RSW'(1) << (F - 1));
			sat_mul[r] = sat_w({{(SATW - HW){h_s3[r][HW-1]}}, h_s3[r]});
			sat_rot[r] = sat_w({{(SATW - RHW){rrnd[r][RSW-1]}}, rrnd[r][RSW-1:F]});
			side_d4.aneg[r] = av_s3[r][W-1];
			side_d4.amag[r] = av_s3[r][W-1] ? W'(-av_s3[r]) : av_s3[r];
			case (func_s3)
				FUNC_MUL: begin
					side_d4.r01[r] = sat_mul[r][W-1:0];
					side_d4.sat01  = side_d4.sat01 | sat_mul[r][W];
				end
				FUNC_ROT: begin
					side_d4.r01[r] = sat_rot[r][W-1:0];
					side_d4.sat01  = side_d4.sat01 | sat_rot[r][W];
				end
				default: begin
					side_d4.r01[r] = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_d4;
			ssq_s4  <= ssq_s3;
		end
	end

	// Square root, one root bit per stage.
	logic [REMW-1:0] rt_rem_s [NR];
	logic [NR-1:0] rt_root_s [NR];
	logic [SW-1:0] rt_sq_s [NR];
	side_t side_rt_s [NR];
	logic vld_rt_s [NR];

	for (genvar k = 0; k < NR; k++) begin : g_rt
		logic [REMW-1:0] rem_in, r2, trial;
		logic [NR-1:0] root_in;
		logic [SW-1:0] sq_in;
		side_t side_in;
		logic vld_in;
		logic take;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign sq_in   = ssq_s4;
			assign side_in = side_s4;
			assign vld_in  = vld_s4;
		end else begin : g_next
			assign rem_in  = rt_rem_s[k-1];
			assign root_in = rt_root_s[k-1];
			assign sq_in   = rt_sq_s[k-1];
			assign side_in = side_rt_s[k-1];
			assign vld_in  = vld_rt_s[k-1];
		end

		assign r2    = {rem_in[REMW-3:0], sq_in[SW-1:SW-2]};
		assign trial = {root_in, 2'b01};
		assign take  = (r2 >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				rt_rem_s[k]  <= take ? r2 - trial : r2;
				rt_root_s[k] <= {root_in[NR-2:0], take};
				rt_sq_s[k]   <= {sq_in[SW-3:0], 2'b00};
				side_rt_s[k] <= side_in;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_rt_s[k] <= 1'b0;
			end else if (en) begin
				vld_rt_s[k] <= vld_in;
			end
		end
	end

	// Four dividers, one quotient bit per stage.
	logic [NW-1:0] dv_rem_s [QB][4];
	logic [QB-1:0] dv_quo_s [QB][4];
	logic [NR-1:0] dv_m_s [QB];
	side_t side_dv_s [QB];
	logic vld_dv_s [QB];

	for (genvar j = 0; j < QB; j++) begin : g_dv
		logic [NW-1:0] rem_in [4];
		logic [QB-1:0] quo_in [4];
		logic [NR-1:0] m_in;
		logic [NW-1:0] dvs;
		side_t side_in;
		logic vld_in;

		if (j == 0) begin : g_first
			assign m_in    = rt_root_s[NR-1];
			assign side_in = side_rt_s[NR-1];
			assign vld_in  = vld_rt_s[NR-1];
			for (genvar i = 0; i < 4; i++) begin : g_lane
				assign rem_in[i] = (NW'(side_in.amag[i]) << F) + NW'(m_in >> 1);
				assign quo_in[i] = '0;
			end
		end else begin : g_next
			assign m_in    = dv_m_s[j-1];
			assign side_in = side_dv_s[j-1];
			assign vld_in  = vld_dv_s[j-1];
			for (genvar i = 0; i < 4; i++) begin : g_lane
				assign rem_in[i] = dv_rem_s[j-1][i];
				assign quo_in[i] = dv_quo_s[j-1][i];
			end
		end

		assign dvs = NW'(m_in) << (QB - 1 - j);

		always_ff @(posedge clk) begin
			if (en) begin
				dv_m_s[j]    <= m_in;
				side_dv_s[j] <= side_in;
				for (int i = 0; i < 4; i++) begin
					dv_rem_s[j][i] <= (rem_in[i] >= dvs) ? rem_in[i] - dvs : rem_in[i];
					dv_quo_s[j][i] <= {quo_in[i][QB-2:0], rem_in[i] >= dvs};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_dv_s[j] <= 1'b0;
			end else if (en) begin
				vld_dv_s[j] <= vld_in;
			end
		end
	end

	// Output register: sign and saturation of the quotients, selection.
	side_t side_fin;
	logic [CW-1:0] quo_ext [4];
	logic signed [W-1:0] r_d [4];
	logic sat_d;
	logic zero_d;

	assign side_fin = side_dv_s[QB-1];

	always_comb begin
		sat_d  = side_fin.sat01;
		zero_d = 1'b0;
		for (int i = 0; i < 4; i++) begin
			quo_ext[i] = CW'(dv_quo_s[QB-1][i]);
			r_d[i]     = side_fin.r01[i];
		end
		if (side_fin.func == FUNC_NORM) begin
			sat_d  = 1'b0;
			zero_d = side_fin.zero;
			for (int i = 0; i < 4; i++) begin
				if (side_fin.zero) begin
					r_d[i] = '0;
				end else if (side_fin.aneg[i]) begin
					if (quo_ext[i] > (CW'(1) << (W - 1))) begin
						sat_d  = 1'b1;
						r_d[i] = {1'b1, {(W - 1){1'b0}}};
					end else begin
						r_d[i] = W'(-quo_ext[i]);
					end
				end else begin
					if (quo_ext[i] > (CW'(1) << (W - 1)) - CW'(1)) begin
						sat_d  = 1'b1;
						r_d[i] = {1'b0, {(W - 1){1'b1}}};
					end else begin
						r_d[i] = quo_ext[i][W-1:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				r_q[i] <= r_d[i];
			end
			sat_q  <= sat_d;
			zero_q <= zero_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_s1      <= in_valid;
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			vld_s4      <= vld_s3;
			out_valid_q <= vld_dv_s[QB-1];
		end
	end

	assign out_valid      = out_valid_q;
	assign r_w            = r_q[0];
	assign r_x            = r_q[1];
	assign r_y            = r_q[2];
	assign r_z            = r_q[3];
	assign saturated      = sat_q;
	assign zero_magnitude = zero_q;

	a_zero_gives_zeros: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_magnitude |-> r_w == '0 && r_x == '0 && r_y == '0 && r_z == '0
			&& !saturated)
		else $error("zero magnitude word carries a nonzero result");

	a_stall_follows_output: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not follow the held result");

	a_held_result_stays: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(r_w) && $stable(r_z)
			&& $stable(saturated))
		else $error("held result changed under stall");

	a_norm_flag_only_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> !zero_magnitude)
		else $error("saturated and zero magnitude both set");

endmodule

### bench/quaternion_arith_unit_test.sv
// Self-checking bench for the quaternion multiply, rotate and normalize unit.
module quaternion_arith_unit_test;
	import qau_pkg::*;

	localparam func_t FUNC_SPARE = 2'd3;

	typedef longint quad_t [4];

	typedef struct {
		func_t              func;
		logic signed [15:0] a [4];
		logic signed [15:0] b [4];
	} qword_t;

	typedef struct {
		logic signed [15:0] r [4];
		logic               sat;
		logic               zero;
	} qres_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	func_t func = FUNC_MUL;
	logic signed [15:0] a_w = 0, a_x = 0, a_y = 0, a_z = 0;
	logic signed [15:0] b_w = 0, b_x = 0, b_y = 0, b_z = 0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [15:0] r_w, r_x, r_y, r_z;
	logic saturated, zero_magnitude;

	qword_t pending_words [$];
	qres_t  expected_results [$];
	qword_t cur_word;
	int total_words = 0;
	int accepted_words = 0;
	int pause_at = 700;
	int mismatches = 0;
	int send_idle_pct = 32;
	int recv_idle_pct = 73;

	quaternion_arith_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .func(func),
		.a_w(a_w), .a_x(a_x), .a_y(a_y), .a_z(a_z),
		.b_w(b_w), .b_x(b_x), .b_y(b_y), .b_z(b_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.r_w(r_w), .r_x(r_x), .r_y(r_y), .r_z(r_z),
		.saturated(saturated), .zero_magnitude(zero_magnitude)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	function automatic quad_t hamilton(quad_t p, quad_t q);
		quad_t o;
		o[0] = p[0]*q[0] - p[1]*q[1] - p[2]*q[2] - p[3]*q[3];
		o[1] = p[0]*q[1] + p[1]*q[0] + p[2]*q[3] - p[3]*q[2];
		o[2] = p[0]*q[2] - p[1]*q[3] + p[2]*q[0] + p[3]*q[1];
		o[3] = p[0]*q[3] + p[1]*q[2] - p[2]*q[1] + p[3]*q[0];
		return o;
	endfunction

	function automatic longint round_q(longint v);
		return (v + 64'sd8192) >>> 14;
	endfunction

	function automatic logic signed [15:0] clip16(longint v, inout logic c);
		if (v > 32767) begin
			c = 1;
			return 16'sh7fff;
		end
		if (v < -32768) begin
			c = 1;
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	function automatic qres_t predict_quaternion(qword_t w);
		qres_t res;
		quad_t a, b, t, c, acc;
		longint s, lo, hi, mid, m, q, mg;
		logic clip;
		clip = 0;
		res.zero = 0;
		for (int i = 0; i < 4; i++) begin
			a[i] = w.a[i];
			b[i] = w.b[i];
			res.r[i] = 0;
		end
		case (w.func)
			FUNC_MUL: begin
				acc = hamilton(a, b);
				for (int i = 0; i < 4; i++) res.r[i] = clip16(round_q(acc[i]), clip);
			end
			FUNC_ROT: begin
				t = '{0, b[1], b[2], b[3]};
				acc = hamilton(a, t);
				for (int i = 0; i < 4; i++) t[i] = round_q(acc[i]);
				c = '{a[0], -a[1], -a[2], -a[3]};
				acc = hamilton(t, c);
				for (int i = 0; i < 4; i++) res.r[i] = clip16(round_q(acc[i]), clip);
			end
			FUNC_NORM: begin
				s = a[0]*a[0] + a[1]*a[1] + a[2]*a[2] + a[3]*a[3];
				if (s == 0) begin
					res.zero = 1;
				end else begin
					lo = 0;
					hi = 64'd1 << 32;
					while (lo < hi) begin
						mid = lo + (hi - lo + 1) / 2;
						if (mid * mid <= s) lo = mid;
						else hi = mid - 1;
					end
					m = lo;
					for (int i = 0; i < 4; i++) begin
						mg = (a[i] < 0) ? -a[i] : a[i];
						q = ((mg << 14) + m / 2) / m;
						res.r[i] = clip16((a[i] < 0) ? -q : q, clip);
					end
				end
			end
			default: ;
		endcase
		res.sat = clip;
		return res;
	endfunction

	function automatic logic signed [15:0] rand_comp();
		case ($urandom_range(5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'($urandom_range(15) - 8);
			3: return 16'($urandom_range(32767) - 16384);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic add_word(func_t f, int aw, int ax, int ay, int az,
			int bw, int bx, int by, int bz);
		qword_t w;
		w.func = f;
		w.a = '{16'(aw), 16'(ax), 16'(ay), 16'(az)};
		w.b = '{16'(bw), 16'(bx), 16'(by), 16'(bz)};
		pending_words.push_back(w);
	endtask

	initial begin
		qword_t w;
		add_word(FUNC_MUL, 16384, 0, 0, 0, 16384, 0, 0, 0);
		add_word(FUNC_MUL, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
		add_word(FUNC_MUL, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
		add_word(FUNC_MUL, 32767, -32768, 32767, -32768, -32768, 32767, -32768, 32767);
		add_word(FUNC_MUL, 0, 16384, 0, 0, 0, 0, 16384, 0);
		add_word(FUNC_MUL, 1, -1, 1, -1, 8192, 8192, -8192, 8192);
		add_word(FUNC_ROT, 11585, 0, 0, 11585, 123, 16384, 0, 0);
		add_word(FUNC_ROT, 32767, 32767, 32767, 32767, 0, 32767, 32767, 32767);
		add_word(FUNC_ROT, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
		add_word(FUNC_ROT, 16384, 0, 0, 0, -1, -32768, 32767, 1);
		add_word(FUNC_ROT, 0, 0, 0, 0, 500, 500, 500, 500);
		add_word(FUNC_NORM, 0, 0, 0, 0, 1, 2, 3, 4);
		add_word(FUNC_NORM, 1, 0, 0, 0, 0, 0, 0, 0);
		add_word(FUNC_NORM, -1, 0, 0, 0, 0, 0, 0, 0);
		add_word(FUNC_NORM, -32768, 0, 0, 0, 0, 0, 0, 0);
		add_word(FUNC_NORM, 32767, 0, 0, 0, 0, 0, 0, 0);
		add_word(FUNC_NORM, 32767, 32767, 32767, 32767, 0, 0, 0, 0);
		add_word(FUNC_NORM, -32768, -32768, -32768, -32768, 0, 0, 0, 0);
		add_word(FUNC_NORM, 1, 1, 1, 1, 0, 0, 0, 0);
		add_word(FUNC_NORM, 3, -4, 0, 0, 0, 0, 0, 0);
		add_word(FUNC_SPARE, 32767, -32768, 5, -5, 32767, -32768, 7, -7);
		add_word(FUNC_SPARE, 0, 0, 0, 0, 0, 0, 0, 0);
		for (int n = 0; n < 1750; n++) begin
			w.func = func_t'($urandom);
			if (w.func == FUNC_SPARE && $urandom_range(3) != 0)
				w.func = func_t'($urandom_range(2));
			for (int i = 0; i < 4; i++) begin
				w.a[i] = rand_comp();
				w.b[i] = rand_comp();
			end
			if (w.func == FUNC_NORM && $urandom_range(15) == 0) w.a = '{0, 0, 0, 0};
			pending_words.push_back(w);
		end
		total_words = pending_words.size();
		repeat (10) @(posedge clk);
		arst_n <= 1;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_results.push_back(predict_quaternion(cur_word));
				accepted_words++;
				if (accepted_words == total_words / 3) begin
					send_idle_pct = 73;
					recv_idle_pct = 32;
				end else if (accepted_words == 2 * total_words / 3) begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			end
			if (!in_valid || !in_stall) begin
				if (pending_words.size() == 0 || $urandom_range(99) < send_idle_pct ||
						(accepted_words == pause_at && expected_results.size() != 0)) begin
					in_valid <= 0;
				end else begin
					cur_word = pending_words.pop_front();
					in_valid <= 1;
					func <= cur_word.func;
					a_w <= cur_word.a[0];
					a_x <= cur_word.a[1];
					a_y <= cur_word.a[2];
					a_z <= cur_word.a[3];
					b_w <= cur_word.b[0];
					b_x <= cur_word.b[1];
					b_y <= cur_word.b[2];
					b_z <= cur_word.b[3];
				end
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		qres_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word r=%0d %0d %0d %0d",
					r_w, r_x, r_y, r_z);
			end else begin
				e = expected_results.pop_front();
				if (r_w !== e.r[0] || r_x !== e.r[1] || r_y !== e.r[2] || r_z !== e.r[3] ||
						saturated !== e.sat || zero_magnitude !== e.zero) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: expected %0d %0d %0d %0d sat %b zero %b, ",
							"got %0d %0d %0d %0d sat %b zero %b"},
							e.r[0], e.r[1], e.r[2], e.r[3], e.sat, e.zero,
							r_w, r_x, r_y, r_z, saturated, zero_magnitude);
				end
			end
		end
	end

	initial begin
		wait (arst_n);
		wait (total_words != 0 && accepted_words == total_words &&
			expected_results.size() == 0);
		repeat (80) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("quaternion_arith_unit verification clean");
		end else begin
			$display("quaternion_arith_unit verification failed");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("quaternion_arith_unit verification failed");
		$finish;
	end

endmodule
